/* rtl/efa_pkg.sv */
package efa_pkg;

    localparam int FREE_ENTRIES = 64;
    localparam int IDX_W        = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int CNT_W        = $clog2(FREE_ENTRIES + 1);
    localparam int CMP_W        = CNT_W + 1;

    localparam int ADDR_W  = 32;
    localparam int REQ_W   = 24;
    localparam int CHUNK_W = 25;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NULL      = 2'd1;
    localparam logic [1:0] ST_NO_HEAP   = 2'd2;
    localparam logic [1:0] ST_LIST_FULL = 2'd3;

    localparam logic [0:0] CFG_HEAP_TOP   = 1'b0;
    localparam logic [0:0] CFG_HEAP_FLOOR = 1'b1;

    localparam logic [ADDR_W-1:0]  HDR_BYTES  = ADDR_W'(8);
    localparam logic [CHUNK_W-1:0] ROUND_ADD  = CHUNK_W'(15);
    localparam logic [CHUNK_W-1:0] ROUND_MASK = ~CHUNK_W'(7);

    typedef struct packed {
        logic               req_type;
        logic [REQ_W-1:0]   request_bytes;
        logic [ADDR_W-1:0]  release_address;
        logic [CHUNK_W-1:0] release_chunk_bytes;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  granted_address;
        logic [CHUNK_W-1:0] granted_chunk_bytes;
        logic               reused;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  chunk_address;
        logic [CHUNK_W-1:0] chunk_bytes;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [CHUNK_W-1:0] chunk_size(input logic [REQ_W-1:0] nbytes);
        logic [CHUNK_W-1:0] sum;
        sum = CHUNK_W'(nbytes) + ROUND_ADD;
        return sum & ROUND_MASK;
    endfunction

    function automatic rsp_t status_only(input logic [1:0] code);
        rsp_t r;
        r                     = '0;
        r.status              = code;
        return r;
    endfunction

endpackage

/* rtl/exact_fit_free_list_allocator_core.sv */
// Exact-fit chunk allocator with a free list and a downward bump cursor.
// Request channel: req_valid / req_stall / req_item. An item is either an
// allocation (size is rounded up to a chunk with an 8-byte header) or a free
// (chunk pushed at the head of the free list). Every item gives one result on
// rsp_valid / rsp_stall / rsp_item, in order.
// Configuration: cfg_we / cfg_index / cfg_data writes heap_top (index 0) or
// heap_floor (index 1); write only while no item is in flight.
// Sequence: a free or a zero-size allocation goes straight to S_DONE, which
// moves the result into the result register once that is free. An allocation
// reads the free-list memory one entry per cycle from the newest entry; on a
// hit, every newer entry is then moved down one place to close the gap; on a
// miss, the chunk is cut from the bump cursor in S_BUMP. The free-list memory
// has a single read port. One item is worked on at a time; req_stall is low
// whenever the block is idle.
// The result register lets the next item be accepted while a result waits;
// a stalled receiver holds rsp_item and the block finishes the next item and
// waits. Reset empties the free list, unloads the cursor (reloaded from
// heap_top on the first bump) and clears both configuration registers.
module exact_fit_free_list_allocator_core
    import efa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req_item,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_t              rsp_item,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [ADDR_W-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_BUMP  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]         state_reg,  state_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [CHUNK_W-1:0] size_reg,   size_next;
    rsp_t               res_reg,    res_next;
    logic [ADDR_W-1:0]  cursor_reg, cursor_next;
    logic               loaded_reg, loaded_next;
    logic [ADDR_W-1:0]  top_reg,    top_next;
    logic [ADDR_W-1:0]  floor_reg,  floor_next;
    rsp_t               rsp_reg,    rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata_raw;
    entry_t             ram_rdata;

    logic               req_fire;
    logic [CMP_W-1:0]   idx_ext;
    logic [CMP_W-1:0]   count_ext;
    logic [ADDR_W-1:0]  bump_base;
    logic [ADDR_W:0]    bump_diff;
    logic [CNT_W-1:0]   count_dec;

    efa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FREE_ENTRIES)
    ) u_free_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = entry_t'(ram_rdata_raw);
    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    assign idx_ext   = CMP_W'(idx_reg);
    assign count_ext = CMP_W'(count_reg);
    assign count_dec = count_reg - CNT_W'(1);
    assign bump_base = loaded_reg ? cursor_reg : top_reg;
    assign bump_diff = {1'b0, bump_base} - (ADDR_W + 1)'(size_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        size_next      = size_reg;
        res_next       = res_reg;
        cursor_next    = cursor_reg;
        loaded_next    = loaded_reg;
        top_next       = top_reg;
        floor_next     = floor_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = idx_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEAP_TOP:   top_next   = cfg_data;
                CFG_HEAP_FLOOR: floor_next = cfg_data;
                default:        top_next   = top_reg;
            endcase
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = count_dec[IDX_W-1:0];
                if (req_fire)
                begin
                    state_next = S_DONE;
                    if (req_item.req_type == REQ_ALLOC)
                    begin
                        size_next = chunk_size(req_item.request_bytes);
                        if (req_item.request_bytes == '0)
                        begin
                            res_next = status_only(ST_NULL);
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_BUMP;
                        end
                        else
                        begin
                            idx_next   = count_dec[IDX_W-1:0];
                            state_next = S_SCAN;
                        end
                    end
                    else if (req_item.release_address == '0)
                    begin
                        res_next = status_only(ST_NULL);
                    end
                    else if (count_ext == CMP_W'(FREE_ENTRIES))
                    begin
                        res_next = status_only(ST_LIST_FULL);
                    end
                    else
                    begin
                        ram_we                  = 1'b1;
                        ram_waddr               = count_reg[IDX_W-1:0];
                        ram_wdata.chunk_address = req_item.release_address - HDR_BYTES;
                        ram_wdata.chunk_bytes   = req_item.release_chunk_bytes;
                        count_next              = count_reg + CNT_W'(1);
                        res_next                = status_only(ST_OK);
                    end
                end
            end

            S_SCAN:
            begin
                if (ram_rdata.chunk_bytes == size_reg)
                begin
                    res_next.granted_address     = ram_rdata.chunk_address + HDR_BYTES;
                    res_next.granted_chunk_bytes = size_reg;
                    res_next.reused              = 1'b1;
                    res_next.status              = ST_OK;
                    if (idx_ext + CMP_W'(1) < count_ext)
                    begin
                        ram_raddr  = idx_reg + IDX_W'(1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_dec;
                        state_next = S_DONE;
                    end
                end
                else if (idx_reg == '0)
                begin
                    state_next = S_BUMP;
                end
                else
                begin
                    idx_next  = idx_reg - IDX_W'(1);
                    ram_raddr = idx_reg - IDX_W'(1);
                end
            end

            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + IDX_W'(1);
                if (idx_ext + CMP_W'(2) < count_ext)
                begin
                    ram_raddr = idx_reg + IDX_W'(2);
                end
                else
                begin
                    count_next = count_dec;
                    state_next = S_DONE;
                end
            end

            S_BUMP:
            begin
                state_next = S_DONE;
                if (bump_diff[ADDR_W] || (bump_diff[ADDR_W-1:0] < floor_reg))
                begin
                    res_next = status_only(ST_NO_HEAP);
                end
                else
                begin
                    cursor_next                  = bump_diff[ADDR_W-1:0];
                    loaded_next                  = 1'b1;
                    res_next.granted_address     = bump_diff[ADDR_W-1:0] + HDR_BYTES;
                    res_next.granted_chunk_bytes = size_reg;
                    res_next.reused              = 1'b0;
                    res_next.status              = ST_OK;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            loaded_reg    <= 1'b0;
            top_reg       <= '0;
            floor_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            loaded_reg    <= loaded_next;
            top_reg       <= top_next;
            floor_reg     <= floor_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        size_reg   <= size_next;
        res_reg    <= res_next;
        cursor_reg <= cursor_next;
        rsp_reg    <= rsp_next;
    end

endmodule

/* rtl/efa_ram.sv */
module efa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/efa_checker.sv */
module efa_checker
    import efa_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp_item
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second item accepted before the first finished");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.status != ST_OK) |->
            (rsp_item.granted_address == '0) && (rsp_item.granted_chunk_bytes == '0)
            && !rsp_item.reused)
        else $error("failed request carries a grant");

    a_chunk_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.granted_chunk_bytes != '0) |->
            (rsp_item.granted_chunk_bytes[2:0] == 3'd0)
            && (rsp_item.granted_chunk_bytes >= CHUNK_W'(16))
            && (rsp_item.status == ST_OK))
        else $error("granted chunk size is not a rounded chunk");

endmodule

bind exact_fit_free_list_allocator_core efa_checker u_efa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
);
